// File: rtl/tgad_pkg.sv
`default_nettype none
package tgad_pkg;

	localparam int ADDR_BITS  = 20;
	localparam int PIX_ADDR_W = 20;
	localparam int ADDR_SUM_W = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 1;
	localparam logic [32:0] SIZE_LIMIT = 33'd1 << ADDR_BITS;

	// header byte offsets
	localparam logic [4:0] HB_ID_LEN = 5'd0;
	localparam logic [4:0] HB_TYPE   = 5'd2;
	localparam logic [4:0] HB_W_LO   = 5'd12;
	localparam logic [4:0] HB_W_HI   = 5'd13;
	localparam logic [4:0] HB_H_LO   = 5'd14;
	localparam logic [4:0] HB_H_HI   = 5'd15;
	localparam logic [4:0] HB_BPP    = 5'd16;
	localparam logic [4:0] HB_DESC   = 5'd17;

	localparam logic [7:0] BPP_24          = 8'd24;
	localparam logic [7:0] BPP_32          = 8'd32;
	localparam logic [7:0] TYPE_TRUECOLOR  = 8'd2;
	localparam logic [7:0] ALPHA_OPAQUE    = 8'hFF;
	localparam int         DESC_ORIGIN_BIT = 5;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_IDSKIP,
		PH_PIXELS,
		PH_IDLE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PIXEL  = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_BPP      = 2'd0,
		ERR_TYPE     = 2'd1,
		ERR_TOO_LARGE = 2'd2
	} err_t;

	typedef struct packed {
		kind_t                  kind;
		logic [PIX_ADDR_W-1:0]  pixel_address;
		logic [31:0]            pixel_bgra;
		logic [15:0]            image_width;
		logic [15:0]            image_height;
		err_t                   error_code;
		logic                   last_pixel;
	} result_t;

endpackage
`default_nettype wire

// File: rtl/tgad_parser.sv
`default_nettype none
module tgad_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        data_byte,
	input  wire logic              file_start,
	input  wire logic              flip_polarity,
	output logic                   res_valid,
	output tgad_pkg::result_t      res
);

	tgad_pkg::phase_t                   phase_q, phase_cur, phase_n;
	logic [4:0]                         hcnt_q, hcnt_cur, hcnt_n;
	logic [7:0]                         id_left_q, id_left_n;
	logic [7:0]                         itype_q, itype_n;
	logic [7:0]                         bpp_q, bpp_n;
	logic [7:0]                         desc_q, desc_n;
	logic [15:0]                        width_q, width_n;
	logic [15:0]                        height_q, height_n;
	logic [31:0]                        size_q;
	logic                               size_ld;
	logic [23:0]                        accum_q, accum_n, accum_upd;
	logic [1:0]                         bip_q, bip_n;
	logic [15:0]                        column_q, column_n;
	logic [15:0]                        rows_left_q, rows_left_n;
	logic [tgad_pkg::ADDR_BITS-1:0]     row_base_q, row_base_n;

	logic [7:0]                         desc_eff;
	logic                               bottom_up;
	logic [31:0]                        size_minus_w;
	logic [tgad_pkg::ADDR_BITS-1:0]     begin_base;
	logic                               too_large;
	logic [tgad_pkg::ADDR_SUM_W-1:0]    addr_sum;
	logic [tgad_pkg::ADDR_BITS-1:0]     addr_m;
	logic [16:0]                        col_inc;
	logic                               last;
	logic                               row_wrap;
	logic                               is32;
	logic                               emit_pix;
	logic [31:0]                        pix;

	assign phase_cur = file_start ? tgad_pkg::PH_HEADER : phase_q;
	assign hcnt_cur  = file_start ? 5'd0 : hcnt_q;

	// descriptor arrives on the same byte that may start the pixel phase
	assign desc_eff     = (phase_cur == tgad_pkg::PH_HEADER) ? data_byte : desc_q;
	assign bottom_up    = desc_eff[tgad_pkg::DESC_ORIGIN_BIT] ^ flip_polarity;
	assign size_minus_w = size_q - {16'd0, width_q};
	assign begin_base   = bottom_up ? size_minus_w[tgad_pkg::ADDR_BITS-1:0] : '0;
	assign too_large    = {1'b0, size_q} > tgad_pkg::SIZE_LIMIT;

	assign addr_sum = tgad_pkg::ADDR_SUM_W'(row_base_q) + tgad_pkg::ADDR_SUM_W'(column_q);
	assign addr_m   = addr_sum[tgad_pkg::ADDR_BITS-1:0];
	assign col_inc  = {1'b0, column_q} + 17'd1;
	assign last     = (rows_left_q == 16'd1) && (col_inc == {1'b0, width_q});
	assign row_wrap = col_inc >= {1'b0, width_q};
	assign is32     = (bpp_q == tgad_pkg::BPP_32);

	always_comb begin
		accum_upd = accum_q;
		case (bip_q)
			2'd0: accum_upd[7:0] = data_byte;
			2'd1: accum_upd[15:8] = data_byte;
			default: accum_upd[23:16] = data_byte;
		endcase
	end

	always_comb begin
		phase_n     = phase_cur;
		hcnt_n      = hcnt_cur;
		id_left_n   = id_left_q;
		itype_n     = itype_q;
		bpp_n       = bpp_q;
		desc_n      = desc_q;
		width_n     = width_q;
		height_n    = height_q;
		size_ld     = 1'b0;
		accum_n     = accum_q;
		bip_n       = bip_q;
		column_n    = column_q;
		rows_left_n = rows_left_q;
		row_base_n  = row_base_q;
		emit_pix    = 1'b0;
		pix         = '0;
		res_valid   = 1'b0;
		res         = '0;

		case (phase_cur)
			tgad_pkg::PH_HEADER: begin
				case (hcnt_cur)
					tgad_pkg::HB_ID_LEN: id_left_n = data_byte;
					tgad_pkg::HB_TYPE:   itype_n = data_byte;
					tgad_pkg::HB_W_LO:   width_n[7:0] = data_byte;
					tgad_pkg::HB_W_HI:   width_n[15:8] = data_byte;
					tgad_pkg::HB_H_LO:   height_n[7:0] = data_byte;
					tgad_pkg::HB_H_HI:   height_n[15:8] = data_byte;
					tgad_pkg::HB_BPP: begin
						bpp_n   = data_byte;
						size_ld = 1'b1;
					end
					tgad_pkg::HB_DESC:   desc_n = data_byte;
					default: ;
				endcase
				if (hcnt_cur != tgad_pkg::HB_DESC) begin
					hcnt_n = hcnt_cur + 5'd1;
				end else begin
					hcnt_n    = 5'd0;
					res_valid = 1'b1;
					if (bpp_q != tgad_pkg::BPP_24 && bpp_q != tgad_pkg::BPP_32) begin
						phase_n        = tgad_pkg::PH_IDLE;
						res.kind       = tgad_pkg::KIND_ERROR;
						res.error_code = tgad_pkg::ERR_BPP;
					end else if (itype_q != tgad_pkg::TYPE_TRUECOLOR) begin
						phase_n        = tgad_pkg::PH_IDLE;
						res.kind       = tgad_pkg::KIND_ERROR;
						res.error_code = tgad_pkg::ERR_TYPE;
					end else if (too_large) begin
						phase_n        = tgad_pkg::PH_IDLE;
						res.kind       = tgad_pkg::KIND_ERROR;
						res.error_code = tgad_pkg::ERR_TOO_LARGE;
					end else begin
						res.kind         = tgad_pkg::KIND_HEADER;
						res.image_width  = width_q;
						res.image_height = height_q;
						if (id_left_q != 8'd0) begin
							phase_n = tgad_pkg::PH_IDSKIP;
						end else begin
							column_n    = '0;
							bip_n       = '0;
							accum_n     = '0;
							rows_left_n = height_q;
							row_base_n  = begin_base;
							phase_n     = (size_q == 32'd0) ? tgad_pkg::PH_IDLE
							                                : tgad_pkg::PH_PIXELS;
						end
					end
				end
			end
			tgad_pkg::PH_IDSKIP: begin
				id_left_n = id_left_q - 8'd1;
				if (id_left_q == 8'd1) begin
					column_n    = '0;
					bip_n       = '0;
					accum_n     = '0;
					rows_left_n = height_q;
					row_base_n  = begin_base;
					phase_n     = (size_q == 32'd0) ? tgad_pkg::PH_IDLE
					                                : tgad_pkg::PH_PIXELS;
				end
			end
			tgad_pkg::PH_PIXELS: begin
				if (bip_q != 2'd3) begin
					accum_n = accum_upd;
					bip_n   = bip_q + 2'd1;
					if (bip_q == 2'd2 && !is32) begin
						emit_pix = 1'b1;
						pix      = {tgad_pkg::ALPHA_OPAQUE, accum_upd};
					end
				end else begin
					emit_pix = 1'b1;
					pix      = {data_byte, accum_q};
				end
				if (emit_pix) begin
					accum_n           = '0;
					bip_n             = '0;
					res_valid         = 1'b1;
					res.kind          = tgad_pkg::KIND_PIXEL;
					res.pixel_address = tgad_pkg::PIX_ADDR_W'(addr_m);
					res.pixel_bgra    = pix;
					res.last_pixel    = last;
					if (row_wrap) begin
						column_n    = '0;
						rows_left_n = rows_left_q - 16'd1;
						if (bottom_up)
							row_base_n = row_base_q - tgad_pkg::ADDR_BITS'(width_q);
						else
							row_base_n = row_base_q + tgad_pkg::ADDR_BITS'(width_q);
					end else begin
						column_n = col_inc[15:0];
					end
					if (last)
						phase_n = tgad_pkg::PH_IDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= tgad_pkg::PH_HEADER;
			hcnt_q      <= '0;
			bip_q       <= '0;
			column_q    <= '0;
			rows_left_q <= '0;
		end else if (step) begin
			phase_q     <= phase_n;
			hcnt_q      <= hcnt_n;
			bip_q       <= bip_n;
			column_q    <= column_n;
			rows_left_q <= rows_left_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			id_left_q  <= id_left_n;
			itype_q    <= itype_n;
			bpp_q      <= bpp_n;
			desc_q     <= desc_n;
			width_q    <= width_n;
			height_q   <= height_n;
			accum_q    <= accum_n;
			row_base_q <= row_base_n;
			// width and height are complete once the bpp byte comes in
			if (size_ld)
				size_q <= 32'(width_q) * 32'(height_q);
		end
	end

endmodule
`default_nettype wire

// File: rtl/tga_truecolor_stream_decoder_core.sv
// Streaming decoder for uncompressed true-color TGA files (image type 2, 24 or 32 bpp).
// Bytes enter one per cycle on in_valid/in_ready; file_start restarts the parse on that
// byte. After the 18-byte header the block returns one item: header accepted (width,
// height) or an error (bad bpp, bad type, image too large, first fault found wins).
// The ID field is skipped, then one pixel item per 3 or 4 bytes carries BGRA (alpha 255
// for 24 bpp) and its buffer address; last_pixel marks the end of the image. A byte is
// taken every cycle while out_ready is high; each byte passes an input register, the
// combinational parser update and a result register. The width*height product is
// formed on header byte 16 and checked on byte 17. flip_polarity chooses which value
// of descriptor bit 5 gives bottom-up rows; write it between files.
`default_nettype none
module tga_truecolor_stream_decoder_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            file_start,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [1:0]                           result_kind,
	output logic [tgad_pkg::PIX_ADDR_W-1:0]      pixel_address,
	output logic [31:0]                          pixel_bgra,
	output logic [15:0]                          image_width,
	output logic [15:0]                          image_height,
	output logic [1:0]                           error_code,
	output logic                                 last_pixel,
	input  wire logic                            cfg_wr_en,
	input  wire logic                            cfg_wr_data
);

	logic               flip_polarity_q;
	logic               valid_s1;
	logic [7:0]         data_s1;
	logic               start_s1;
	logic               proc;
	logic               res_valid;
	tgad_pkg::result_t  res;
	logic               out_valid_q;
	tgad_pkg::result_t  res_q;

	assign proc     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_polarity_q <= 1'b0;
		end else if (cfg_wr_en) begin
			flip_polarity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= data_byte;
			start_s1 <= file_start;
		end
	end

	tgad_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (proc),
		.data_byte     (data_s1),
		.file_start    (start_s1),
		.flip_polarity (flip_polarity_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_valid)
			res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = res_q.kind;
	assign pixel_address = res_q.pixel_address;
	assign pixel_bgra    = res_q.pixel_bgra;
	assign image_width   = res_q.image_width;
	assign image_height  = res_q.image_height;
	assign error_code    = res_q.error_code;
	assign last_pixel    = res_q.last_pixel;

	// an empty result register always frees the input stage
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");

	a_nonpixel_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind != tgad_pkg::KIND_PIXEL |->
			res_q.pixel_bgra == 32'd0 && !res_q.last_pixel && res_q.pixel_address == '0)
		else $error("pixel fields set on non-pixel item");

	a_error_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == tgad_pkg::KIND_ERROR |->
			res_q.error_code != 2'd3 && res_q.image_width == 16'd0)
		else $error("malformed error item");

endmodule
`default_nettype wire

// File: tb/sv/tb_tga_truecolor_stream_decoder_core.sv
`timescale 1ns / 100ps
module tb_tga_truecolor_stream_decoder_core;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          HOLD_CYCLES = 300;
	localparam int          DRAIN_CYCLES = 6;
	localparam int unsigned RANDOM_BYTES = 40;
	localparam logic [63:0] ADDR_MASK = (64'd1 << tgad_pkg::ADDR_BITS) - 64'd1;

	typedef struct {
		logic [7:0] data;
		bit         start;
	} byte_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        file_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  result_kind;
	logic [tgad_pkg::PIX_ADDR_W-1:0] pixel_address;
	logic [31:0] pixel_bgra;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [1:0]  error_code;
	logic        last_pixel;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;

	byte_item_t          pending_bytes[$];
	tgad_pkg::result_t   expected_results[$];
	byte_item_t          next_item;

	// decoder state mirrored by the predictor
	tgad_pkg::phase_t parse_ph;
	logic [4:0]  hdr_count;
	logic [7:0]  id_left;
	logic [7:0]  img_type;
	logic [7:0]  img_bpp;
	logic [7:0]  img_desc;
	logic [15:0] img_w;
	logic [15:0] img_h;
	logic [23:0] accum;
	logic [1:0]  pix_idx;
	logic [15:0] col;
	logic [15:0] rows_left;
	logic [63:0] row_base;
	logic        origin_flip;

	bit          idle_on = 1'b1;
	bit          hold_go = 1'b0;
	bit          hold_done = 1'b0;
	bit          rx_hold = 1'b0;
	int          hold_count = 0;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	int unsigned cycles = 0;
	int unsigned stim_bytes = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned n_pixels = 0;
	int unsigned n_headers = 0;
	int unsigned n_errors = 0;

	tga_truecolor_stream_decoder_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.file_start    (file_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.pixel_address (pixel_address),
		.pixel_bgra    (pixel_bgra),
		.image_width   (image_width),
		.image_height  (image_height),
		.error_code    (error_code),
		.last_pixel    (last_pixel),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic logic rows_bottom_up();
		return img_desc[tgad_pkg::DESC_ORIGIN_BIT] ^ origin_flip;
	endfunction

	task automatic restart_parse();
		parse_ph = tgad_pkg::PH_HEADER;
		hdr_count = '0;
		id_left = '0;
		img_type = '0;
		img_bpp = '0;
		img_desc = '0;
		img_w = '0;
		img_h = '0;
		accum = '0;
		pix_idx = '0;
		col = '0;
		rows_left = '0;
		row_base = '0;
	endtask

	task automatic start_pixels();
		logic [63:0] area;
		area = 64'(img_w) * 64'(img_h);
		col = '0;
		pix_idx = '0;
		accum = '0;
		rows_left = img_h;
		if (area == 0) begin
			parse_ph = tgad_pkg::PH_IDLE;
		end else begin
			row_base = rows_bottom_up() ? ((area - 64'(img_w)) & ADDR_MASK) : 64'd0;
			parse_ph = tgad_pkg::PH_PIXELS;
		end
	endtask

	// Advance the decoder by one accepted byte; queue the result it produces, if any.
	task automatic decode_byte(input logic [7:0] b, input logic fs);
		tgad_pkg::result_t r;
		logic [63:0] area;
		logic [63:0] addr;
		logic [31:0] pix;
		logic [2:0]  nbytes;
		logic        pix_done;
		logic        is_last;
		if (fs)
			restart_parse();
		r = '0;
		case (parse_ph)
			tgad_pkg::PH_HEADER: begin
				case (hdr_count)
					tgad_pkg::HB_ID_LEN: id_left = b;
					tgad_pkg::HB_TYPE:   img_type = b;
					tgad_pkg::HB_W_LO:   img_w[7:0] = b;
					tgad_pkg::HB_W_HI:   img_w[15:8] = b;
					tgad_pkg::HB_H_LO:   img_h[7:0] = b;
					tgad_pkg::HB_H_HI:   img_h[15:8] = b;
					tgad_pkg::HB_BPP:    img_bpp = b;
					tgad_pkg::HB_DESC:   img_desc = b;
					default:   ;
				endcase
				if (hdr_count != tgad_pkg::HB_DESC) begin
					hdr_count++;
				end else begin
					hdr_count = '0;
					area = 64'(img_w) * 64'(img_h);
					// first fault found wins: bpp, then type, then size
					if (img_bpp != tgad_pkg::BPP_24 && img_bpp != tgad_pkg::BPP_32) begin
						parse_ph = tgad_pkg::PH_IDLE;
						r.kind = tgad_pkg::KIND_ERROR;
						r.error_code = tgad_pkg::ERR_BPP;
					end else if (img_type != tgad_pkg::TYPE_TRUECOLOR) begin
						parse_ph = tgad_pkg::PH_IDLE;
						r.kind = tgad_pkg::KIND_ERROR;
						r.error_code = tgad_pkg::ERR_TYPE;
					end else if (area > 64'(tgad_pkg::SIZE_LIMIT)) begin
						parse_ph = tgad_pkg::PH_IDLE;
						r.kind = tgad_pkg::KIND_ERROR;
						r.error_code = tgad_pkg::ERR_TOO_LARGE;
					end else begin
						r.kind = tgad_pkg::KIND_HEADER;
						r.image_width = img_w;
						r.image_height = img_h;
						if (id_left != 0)
							parse_ph = tgad_pkg::PH_IDSKIP;
						else
							start_pixels();
					end
					expected_results.push_back(r);
				end
			end
			tgad_pkg::PH_IDSKIP: begin
				id_left--;
				if (id_left == 0)
					start_pixels();
			end
			tgad_pkg::PH_PIXELS: begin
				nbytes = (img_bpp == tgad_pkg::BPP_32) ? 3'd4 : 3'd3;
				pix_done = 1'b0;
				if (pix_idx < 3) begin
					accum[pix_idx*8 +: 8] = b;
					pix_idx++;
					pix = {tgad_pkg::ALPHA_OPAQUE, accum};
					pix_done = ({1'b0, pix_idx} == nbytes);
				end else begin
					pix = {b, accum};
					pix_done = 1'b1;
				end
				if (pix_done) begin
					pix_idx = '0;
					accum = '0;
					is_last = (rows_left == 16'd1) && (17'(col) + 17'd1 == 17'(img_w));
					addr = (row_base + 64'(col)) & ADDR_MASK;
					r.kind = tgad_pkg::KIND_PIXEL;
					r.pixel_address = addr[tgad_pkg::PIX_ADDR_W-1:0];
					r.pixel_bgra = pix;
					r.last_pixel = is_last;
					col++;
					if (col >= img_w) begin
						col = '0;
						rows_left--;
						if (rows_bottom_up())
							row_base = (row_base - 64'(img_w)) & ADDR_MASK;
						else
							row_base = (row_base + 64'(img_w)) & ADDR_MASK;
					end
					if (is_last)
						parse_ph = tgad_pkg::PH_IDLE;
					expected_results.push_back(r);
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h",
				$time, results_seen, field, got, want);
	endtask

	task automatic check_result();
		tgad_pkg::result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with none pending", 64'(result_kind), 64'd0);
		end else begin
			want = expected_results.pop_front();
			results_seen++;
			case (want.kind)
				tgad_pkg::KIND_PIXEL:  n_pixels++;
				tgad_pkg::KIND_HEADER: n_headers++;
				default:     n_errors++;
			endcase
			if (result_kind !== want.kind)
				report_mismatch("result_kind", 64'(result_kind), 64'(want.kind));
			if (pixel_address !== want.pixel_address)
				report_mismatch("pixel_address", 64'(pixel_address),
					64'(want.pixel_address));
			if (pixel_bgra !== want.pixel_bgra)
				report_mismatch("pixel_bgra", 64'(pixel_bgra), 64'(want.pixel_bgra));
			if (image_width !== want.image_width)
				report_mismatch("image_width", 64'(image_width), 64'(want.image_width));
			if (image_height !== want.image_height)
				report_mismatch("image_height", 64'(image_height),
					64'(want.image_height));
			if (error_code !== want.error_code)
				report_mismatch("error_code", 64'(error_code), 64'(want.error_code));
			if (last_pixel !== want.last_pixel)
				report_mismatch("last_pixel", 64'(last_pixel), 64'(want.last_pixel));
		end
	endtask

	// byte driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				decode_byte(data_byte, file_start);
			if (!in_valid || in_ready) begin
				if (tx_gap != 0) begin
					in_valid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (pending_bytes.size() != 0) begin
					next_item = pending_bytes.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_item.data;
					file_start <= next_item.start;
					tx_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (rx_gap != 0) begin
				out_ready <= 1'b0;
				rx_gap <= rx_gap - 1;
			end else if (rx_hold) begin
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				rx_gap <= pick_gap();
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off so the pipeline backs up into the input
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_hold <= 1'b0;
			hold_count <= 0;
			hold_done <= 1'b0;
		end else if (hold_go && !hold_done) begin
			if (hold_count == HOLD_CYCLES) begin
				rx_hold <= 1'b0;
				hold_done <= 1'b1;
			end else begin
				rx_hold <= 1'b1;
				hold_count <= hold_count + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_tga_truecolor_stream_decoder_core: FAIL");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b, input bit fs);
		pending_bytes.push_back('{data: b, start: fs});
		stim_bytes++;
	endtask

	task automatic push_body(input int unsigned n);
		repeat (n)
			push_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic push_header(input bit fs, input logic [7:0] id_len,
			input logic [7:0] itype, input logic [15:0] w, input logic [15:0] h,
			input logic [7:0] bpp, input logic [7:0] desc);
		push_byte(id_len, fs);
		push_body(1);
		push_byte(itype, 1'b0);
		push_body(9);
		push_byte(w[7:0], 1'b0);
		push_byte(w[15:8], 1'b0);
		push_byte(h[7:0], 1'b0);
		push_byte(h[15:8], 1'b0);
		push_byte(bpp, 1'b0);
		push_byte(desc, 1'b0);
	endtask

	task automatic directed_files(input bit first_bare, input bit long_id);
		// first file may arrive without a file_start, as straight after reset
		push_header(!first_bare, 8'd0, tgad_pkg::TYPE_TRUECOLOR, 16'd3, 16'd2,
			tgad_pkg::BPP_24, 8'h00);
		push_body(18 + 3);
		push_header(1'b1, 8'd3, tgad_pkg::TYPE_TRUECOLOR, 16'd2, 16'd3,
			tgad_pkg::BPP_32, 8'h20);
		push_body(3 + 24);
		// bad bpp and bad type together: bpp is reported, trailing bytes dropped
		push_header(1'b1, 8'd0, 8'd10, 16'd4, 16'd4, 8'd16, 8'h00);
		push_body(4);
		push_header(1'b1, 8'd0, tgad_pkg::TYPE_TRUECOLOR, 16'd1, 16'd1, 8'hFF, 8'h00);
		push_header(1'b1, 8'd0, 8'hFF, 16'd4, 16'd4, tgad_pkg::BPP_32, 8'h00);
		push_header(1'b1, 8'd0, tgad_pkg::TYPE_TRUECOLOR, 16'd1025, 16'd1024,
			tgad_pkg::BPP_24, 8'h00);
		push_header(1'b1, 8'd0, tgad_pkg::TYPE_TRUECOLOR, 16'hFFFF, 16'hFFFF,
			tgad_pkg::BPP_32, 8'hFF);
		// exactly fills the address space; send a few pixels only
		push_header(1'b1, 8'd0, tgad_pkg::TYPE_TRUECOLOR, 16'd1024, 16'd1024,
			tgad_pkg::BPP_32, 8'h20);
		push_body(8);
		push_header(1'b1, 8'd0, tgad_pkg::TYPE_TRUECOLOR, 16'hFFFF, 16'd16,
			tgad_pkg::BPP_24, 8'h20);
		push_body(9);
		push_header(1'b1, 8'd0, tgad_pkg::TYPE_TRUECOLOR, 16'd0, 16'd5,
			tgad_pkg::BPP_24, 8'h00);
		push_body(3);
		push_header(1'b1, 8'd0, tgad_pkg::TYPE_TRUECOLOR, 16'd7, 16'd0,
			tgad_pkg::BPP_32, 8'h20);
		// restart in the middle of a header
		push_byte(8'd1, 1'b1);
		push_body(6);
		push_header(1'b1, 8'd1, tgad_pkg::TYPE_TRUECOLOR, 16'd1, 16'd1,
			tgad_pkg::BPP_24, 8'h00);
		push_body(1 + 3);
		push_header(1'b1, 8'd0, tgad_pkg::TYPE_TRUECOLOR, 16'd2, 16'd1,
			tgad_pkg::BPP_32, 8'hDF);
		repeat (4)
			push_byte(8'h00, 1'b0);
		repeat (4)
			push_byte(8'hFF, 1'b0);
		if (long_id) begin
			push_header(1'b1, 8'd255, tgad_pkg::TYPE_TRUECOLOR, 16'd1, 16'd2,
				tgad_pkg::BPP_32, 8'hC0);
			push_body(255 + 8);
		end
	endtask

	task automatic random_file(input bit opening);
		int unsigned sel;
		int unsigned w;
		int unsigned h;
		int unsigned hmax;
		int unsigned id;
		int unsigned nb;
		logic [7:0]  bpp;
		logic [7:0]  desc;
		logic [7:0]  code;
		sel = opening ? 0 : $urandom_range(0, 99);
		bpp = $urandom_range(0, 1) ? tgad_pkg::BPP_32 : tgad_pkg::BPP_24;
		nb = (bpp == tgad_pkg::BPP_32) ? 4 : 3;
		w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
		h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
		id = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		desc = 8'($urandom_range(0, 255));
		if (sel < 72) begin
			push_header(1'b1, 8'(id), tgad_pkg::TYPE_TRUECOLOR, 16'(w), 16'(h), bpp, desc);
			push_body(id + w * h * nb);
			if ($urandom_range(0, 6) == 0)
				push_body($urandom_range(1, 4));
		end else if (sel < 80) begin
			// cut short, in the header or in the body
			if ($urandom_range(0, 1)) begin
				push_byte(8'(id), 1'b1);
				push_body($urandom_range(0, 16));
			end else begin
				push_header(1'b1, 8'(id), tgad_pkg::TYPE_TRUECOLOR, 16'(w), 16'(h),
					bpp, desc);
				push_body($urandom_range(0, id + w * h * nb));
			end
		end else if (sel < 85) begin
			code = 8'($urandom_range(0, 255));
			if (code == tgad_pkg::BPP_24 || code == tgad_pkg::BPP_32)
				code++;
			push_header(1'b1, 8'(id), 8'($urandom_range(0, 255)), 16'(w), 16'(h),
				code, desc);
			push_body($urandom_range(0, 6));
		end else if (sel < 89) begin
			code = 8'($urandom_range(0, 255));
			if (code == tgad_pkg::TYPE_TRUECOLOR)
				code++;
			push_header(1'b1, 8'(id), code, 16'(w), 16'(h), bpp, desc);
			push_body($urandom_range(0, 6));
		end else if (sel < 93) begin
			push_header(1'b1, 8'(id), tgad_pkg::TYPE_TRUECOLOR,
				16'($urandom_range(1025, 65535)), 16'($urandom_range(1024, 65535)),
				bpp, desc);
		end else if (sel < 97) begin
			// large image that still fits: only its first few pixels
			w = $urandom_range(1, 65535);
			hmax = 1048576 / w;
			if (hmax > 65535)
				hmax = 65535;
			h = $urandom_range(1, hmax);
			push_header(1'b1, 8'(id), tgad_pkg::TYPE_TRUECOLOR, 16'(w), 16'(h), bpp, desc);
			push_body(id + $urandom_range(1, 6) * nb);
		end else begin
			repeat ($urandom_range(4, 30))
				push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
		end
	endtask

	task automatic write_flip(input logic v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		origin_flip = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// hold until every byte is taken and every result checked, then let the pipe empty
	task automatic wait_drained();
		@(posedge clk);
		while (!(pending_bytes.size() == 0 && !in_valid && expected_results.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		int          phase_no;
		int unsigned start_count;
		restart_parse();
		origin_flip = 1'b0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;

		write_flip(1'b0);
		@(negedge clk);
		directed_files(1'b1, 1'b1);
		wait_drained();

		for (phase_no = 0; phase_no < 4; phase_no++) begin
			write_flip(~phase_no[0]);
			if (phase_no == 1)
				hold_go <= 1'b1;
			@(negedge clk);
			idle_on = (phase_no != 2);
			start_count = stim_bytes;
			random_file(1'b1);
			while (stim_bytes - start_count < RANDOM_BYTES)
				random_file(1'b0);
			wait_drained();
		end

		$display("Sent %0d file bytes under both row-order polarities, with gaps and a %0d-cycle",
			stim_bytes, HOLD_CYCLES);
		$display("output stall; checked %0d results: %0d pixels, %0d headers, %0d errors.",
			results_seen, n_pixels, n_headers, n_errors);
		if (mismatches == 0)
			$display("tb_tga_truecolor_stream_decoder_core: PASS");
		else
			$display("tb_tga_truecolor_stream_decoder_core: FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/tgad_pkg.sv
rtl/tgad_parser.sv
rtl/tga_truecolor_stream_decoder_core.sv
tb/sv/tb_tga_truecolor_stream_decoder_core.sv
